[rtl/fcr_pkg.sv]
`timescale 1ns / 1ps

package fcr_pkg;

  // frames with a size byte at or above this are dropped
  localparam int unsigned MaxPayload = 16;
  localparam logic [7:0] MaxPayloadB = 8'(MaxPayload);

  localparam logic [7:0] StartByte = 8'h3C;
  localparam logic [7:0] EndByte   = 8'h3E;

  localparam logic [7:0] CmdReadLevel = 8'd0;
  localparam logic [7:0] CmdReadAll   = 8'd1;
  localparam logic [7:0] CmdReadPot   = 8'd2;
  localparam logic [7:0] CmdSetSleep  = 8'd3;
  localparam logic [7:0] CmdSetLevel  = 8'd4;

  // size and command bytes of the reply frames
  localparam logic [7:0] ReplySizeOne = 8'd1;
  localparam logic [7:0] ReplySizeTwo = 8'd2;
  localparam logic [7:0] ReplyCodeOne = 8'd1;
  localparam logic [7:0] ReplyCodeTwo = 8'd2;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    PsWait,
    PsSize,
    PsCmd,
    PsData,
    PsCheck
  } parse_state_e;

  typedef enum logic [1:0] {
    JobStatus,
    JobLevel,
    JobBoth,
    JobPot
  } job_kind_e;

  typedef logic [2:0] word_idx_t;

  localparam word_idx_t IdxStart = 3'd0;
  localparam word_idx_t IdxSize  = 3'd1;
  localparam word_idx_t IdxCode  = 3'd2;
  localparam word_idx_t IdxFirst = 3'd3;
  localparam word_idx_t IdxFifth = 3'd4;
  localparam word_idx_t IdxSixth = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       switch_on;
    logic [7:0] pot_value;
  } in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  reply_byte;
    logic        last;
    logic [7:0]  lamp_level;
    logic [7:0]  sleep_mode;
    logic [15:0] error_count;
  } out_t;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  level;
    logic [7:0]  sleep;
    logic [15:0] errors;
    logic [7:0]  pot;
  } job_t;

endpackage

[rtl/fcr_front.sv]
`timescale 1ns / 1ps

module fcr_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  fcr_pkg::in_t in_data_i,
  input  logic         full_i,
  output logic         push_o,
  output fcr_pkg::job_t job_o
);

  fcr_pkg::parse_state_e state_q, state_d;
  logic [7:0]  size_q, size_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  level_q, level_d;
  logic [7:0]  sleep_q, sleep_d;
  logic [15:0] errors_q, errors_d;
  logic        accept;
  logic [7:0]  count_inc;
  fcr_pkg::job_kind_e kind;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign count_inc  = 8'(count_q + 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fcr_pkg::PsWait;
      size_q   <= '0;
      count_q  <= '0;
      cmd_q    <= '0;
      first_q  <= '0;
      level_q  <= '0;
      sleep_q  <= '0;
      errors_q <= '0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      count_q  <= count_d;
      cmd_q    <= cmd_d;
      first_q  <= first_d;
      level_q  <= level_d;
      sleep_q  <= sleep_d;
      errors_q <= errors_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    size_d   = size_q;
    count_d  = count_q;
    cmd_d    = cmd_q;
    first_d  = first_q;
    level_d  = level_q;
    sleep_d  = sleep_q;
    errors_d = errors_q;
    kind     = fcr_pkg::JobStatus;
    if (accept) begin
      unique case (state_q)
        fcr_pkg::PsSize: begin
          size_d  = in_data_i.rx_byte;
          state_d = (in_data_i.rx_byte >= fcr_pkg::MaxPayloadB) ? fcr_pkg::PsWait
                                                                 : fcr_pkg::PsCmd;
        end
        fcr_pkg::PsCmd: begin
          cmd_d   = in_data_i.rx_byte;
          state_d = (size_q != 8'd0) ? fcr_pkg::PsData : fcr_pkg::PsCheck;
        end
        fcr_pkg::PsData: begin
          if (count_q == 8'd0) begin
            first_d = in_data_i.rx_byte;
          end
          count_d = count_inc;
          if (count_inc == size_q) begin
            state_d = fcr_pkg::PsCheck;
          end
        end
        fcr_pkg::PsCheck: begin
          state_d = fcr_pkg::PsWait;
          if (in_data_i.rx_byte == fcr_pkg::EndByte) begin
            unique case (cmd_q)
              fcr_pkg::CmdReadLevel: kind = fcr_pkg::JobLevel;
              fcr_pkg::CmdReadAll:   kind = fcr_pkg::JobBoth;
              fcr_pkg::CmdReadPot:   kind = fcr_pkg::JobPot;
              fcr_pkg::CmdSetSleep:  sleep_d = first_q;
              fcr_pkg::CmdSetLevel: begin
                if (in_data_i.switch_on) begin
                  level_d = first_q;
                end
              end
              default: ;
            endcase
          end else begin
            errors_d = 16'(errors_q + 16'd1);
          end
        end
        default: begin
          // idle, and any code the parser never reaches
          state_d = fcr_pkg::PsWait;
          if (in_data_i.rx_byte == fcr_pkg::StartByte) begin
            state_d = fcr_pkg::PsSize;
            count_d = '0;
          end
        end
      endcase
    end
  end

  // the job carries the register values as they stand after this word
  always_comb begin
    job_o.kind   = kind;
    job_o.level  = level_d;
    job_o.sleep  = sleep_d;
    job_o.errors = errors_d;
    job_o.pot    = in_data_i.pot_value;
  end

endmodule

[rtl/fcr_queue.sv]
`timescale 1ns / 1ps

module fcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fcr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output fcr_pkg::job_t job_o
);

  fcr_pkg::job_t mem_q [fcr_pkg::QueueDepth];
  logic [fcr_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [fcr_pkg::QueueCntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o  = (count_q == fcr_pkg::QueueCntW'(fcr_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == fcr_pkg::QueuePtrW'(fcr_pkg::QueueDepth - 1)) ? '0
                    : fcr_pkg::QueuePtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == fcr_pkg::QueuePtrW'(fcr_pkg::QueueDepth - 1)) ? '0
                    : fcr_pkg::QueuePtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= fcr_pkg::QueueCntW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= fcr_pkg::QueueCntW'(count_q - 1'b1);
      end
    end
  end

endmodule

[rtl/fcr_back.sv]
`timescale 1ns / 1ps

module fcr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  fcr_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fcr_pkg::out_t out_data_o
);

  fcr_pkg::job_t     cur_q;
  logic              cur_valid_q;
  fcr_pkg::word_idx_t idx_q;
  logic              out_valid_q;
  fcr_pkg::out_t     out_q;
  fcr_pkg::out_t     word;
  logic              out_free;
  logic              cur_last;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // build the word for the current job at the current position
  always_comb begin
    word.byte_valid  = 1'b1;
    word.reply_byte  = '0;
    word.last        = 1'b0;
    word.lamp_level  = cur_q.level;
    word.sleep_mode  = cur_q.sleep;
    word.error_count = cur_q.errors;
    unique case (cur_q.kind)
      fcr_pkg::JobStatus: begin
        word.byte_valid = 1'b0;
        word.last       = 1'b1;
      end
      fcr_pkg::JobBoth: begin
        word.last = (idx_q == fcr_pkg::IdxSixth);
        unique case (idx_q)
          fcr_pkg::IdxStart: word.reply_byte = fcr_pkg::StartByte;
          fcr_pkg::IdxSize:  word.reply_byte = fcr_pkg::ReplySizeTwo;
          fcr_pkg::IdxCode:  word.reply_byte = fcr_pkg::ReplyCodeOne;
          fcr_pkg::IdxFirst: word.reply_byte = cur_q.level;
          fcr_pkg::IdxFifth: word.reply_byte = cur_q.sleep;
          default:           word.reply_byte = fcr_pkg::EndByte;
        endcase
      end
      default: begin
        // level or pot read: five-word reply
        word.last = (idx_q == fcr_pkg::IdxFifth);
        unique case (idx_q)
          fcr_pkg::IdxStart: word.reply_byte = fcr_pkg::StartByte;
          fcr_pkg::IdxSize:  word.reply_byte = fcr_pkg::ReplySizeOne;
          fcr_pkg::IdxCode:  word.reply_byte = fcr_pkg::ReplyCodeTwo;
          fcr_pkg::IdxFirst: word.reply_byte = (cur_q.kind == fcr_pkg::JobPot) ? cur_q.pot
                                                                               : cur_q.level;
          default:           word.reply_byte = fcr_pkg::EndByte;
        endcase
      end
    endcase
  end

  assign cur_last = word.last;
  // take the next job while the last word of this one goes out, or when no job is held
  assign pop_o    = out_free && (!cur_valid_q || cur_last) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cur_valid_q;
      if (cur_valid_q && !cur_last) begin
        idx_q <= fcr_pkg::word_idx_t'(idx_q + 3'd1);
      end else begin
        cur_valid_q <= !empty_i;
        idx_q       <= fcr_pkg::IdxStart;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cur_valid_q) begin
      out_q <= word;
    end
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

endmodule

[rtl/framed_command_receiver.sv]
`timescale 1ns / 1ps

// Frame parser for a '<' size command payload '>' byte stream. One received
// byte is taken per clock while the four-entry job queue has room; the parser
// updates lamp level, sleep mode and the bad-frame counter at once and queues
// one job per byte. The output side turns each job into one status word, or
// into five or six reply words for the read commands, at one word per clock
// while the output is not stalled, through a registered output stage, so the
// output word rate sets the long-run throughput.
// Input stall rises only when the job queue is full.
module framed_command_receiver (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fcr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fcr_pkg::out_t out_data_o
);

  logic          push, full, pop, empty;
  fcr_pkg::job_t push_job, head_job;

  fcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  fcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  fcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[test/framed_command_receiver_tb.sv]
`timescale 1ns / 1ps

module framed_command_receiver_tb;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned FrameItems = 410;  // directed part plus random frames
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailWords  = 60;

  typedef struct {
    fcr_pkg::in_t word;
    bit           drain;  // wait for every reply word before offering this one
  } pending_word_t;

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  fcr_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  fcr_pkg::out_t out_data_o;

  framed_command_receiver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // parser and lamp state as the block should hold it
  fcr_pkg::parse_state_e parser_st    = fcr_pkg::PsWait;
  logic [7:0]            frame_len    = '0;
  logic [7:0]            payload_seen = '0;
  logic [7:0]            cmd_code     = '0;
  logic [7:0]            first_data   = '0;
  logic [7:0]            lamp_lvl     = '0;
  logic [7:0]            sleep_lvl    = '0;
  logic [15:0]           bad_term_cnt = '0;

  pending_word_t rx_words_q[$];
  fcr_pkg::out_t reply_words_q[$];

  int unsigned accepted_cnt = 0;
  int unsigned error_cnt    = 0;
  int unsigned stuck_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          want_drain   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void take_rx_word(fcr_pkg::in_t w);
    logic [7:0]    reply [6];
    int            n;
    fcr_pkg::out_t r;
    n = 0;
    case (parser_st)
      fcr_pkg::PsSize: begin
        frame_len = w.rx_byte;
        parser_st = (w.rx_byte >= fcr_pkg::MaxPayloadB) ? fcr_pkg::PsWait : fcr_pkg::PsCmd;
      end
      fcr_pkg::PsCmd: begin
        cmd_code  = w.rx_byte;
        parser_st = (frame_len != 0) ? fcr_pkg::PsData : fcr_pkg::PsCheck;
      end
      fcr_pkg::PsData: begin
        if (payload_seen == 0) first_data = w.rx_byte;
        payload_seen++;
        if (payload_seen == frame_len) parser_st = fcr_pkg::PsCheck;
      end
      fcr_pkg::PsCheck: begin
        parser_st = fcr_pkg::PsWait;
        if (w.rx_byte == fcr_pkg::EndByte) begin
          case (cmd_code)
            fcr_pkg::CmdReadLevel: begin
              reply = '{fcr_pkg::StartByte, fcr_pkg::ReplySizeOne, fcr_pkg::ReplyCodeTwo,
                        lamp_lvl, fcr_pkg::EndByte, 8'h00};
              n = 5;
            end
            fcr_pkg::CmdReadAll: begin
              reply = '{fcr_pkg::StartByte, fcr_pkg::ReplySizeTwo, fcr_pkg::ReplyCodeOne,
                        lamp_lvl, sleep_lvl, fcr_pkg::EndByte};
              n = 6;
            end
            fcr_pkg::CmdReadPot: begin
              reply = '{fcr_pkg::StartByte, fcr_pkg::ReplySizeOne, fcr_pkg::ReplyCodeTwo,
                        w.pot_value, fcr_pkg::EndByte, 8'h00};
              n = 5;
            end
            fcr_pkg::CmdSetSleep: sleep_lvl = first_data;
            fcr_pkg::CmdSetLevel: if (w.switch_on) lamp_lvl = first_data;
            default: ;
          endcase
        end else begin
          bad_term_cnt++;
        end
      end
      default: begin
        parser_st = fcr_pkg::PsWait;
        if (w.rx_byte == fcr_pkg::StartByte) begin
          parser_st    = fcr_pkg::PsSize;
          payload_seen = '0;
        end
      end
    endcase

    r.lamp_level  = lamp_lvl;
    r.sleep_mode  = sleep_lvl;
    r.error_count = bad_term_cnt;
    if (n == 0) begin
      r.byte_valid = 1'b0;
      r.reply_byte = '0;
      r.last       = 1'b1;
      reply_words_q.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.byte_valid = 1'b1;
        r.reply_byte = reply[i];
        r.last       = (i == n - 1);
        reply_words_q.push_back(r);
      end
    end
  endfunction

  function automatic void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      error_cnt++;
    end
  endfunction

  function automatic bit idle_allowed();
    return rx_words_q.size() > TailWords && (accepted_cnt % 128) < 96;
  endfunction

  function automatic void push_word(logic [7:0] b, bit sw, logic [7:0] pot);
    pending_word_t p;
    p.word.rx_byte   = b;
    p.word.switch_on = sw;
    p.word.pot_value = pot;
    p.drain          = want_drain;
    want_drain       = 1'b0;
    rx_words_q.push_back(p);
  endfunction

  // an oversized frame stops after its size byte, as the parser does
  function automatic void push_frame(logic [7:0] len, logic [7:0] code, logic [7:0] first,
                                     logic [7:0] term, bit sw, logic [7:0] pot);
    push_word(fcr_pkg::StartByte, sw, pot);
    push_word(len, sw, pot);
    if (len < fcr_pkg::MaxPayloadB) begin
      push_word(code, sw, pot);
      for (int i = 0; i < len; i++) push_word((i == 0) ? first : 8'($urandom), sw, pot);
      push_word(term, sw, pot);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    pending_word_t head;
    bit            send;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        take_rx_word(in_data_i);
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        send = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (rx_words_q.size() != 0 &&
                     !(rx_words_q[0].drain && reply_words_q.size() != 0)) begin
          head = rx_words_q.pop_front();
          send = 1'b1;
          in_data_i <= head.word;
          if (idle_allowed() && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
        end
        in_valid_i <= send;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i) begin
    fcr_pkg::out_t exp_w;
    bit            stall_nx;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_words_q.size() == 0) begin
          $error("unexpected output word %p", out_data_o);
          error_cnt++;
        end else begin
          exp_w = reply_words_q.pop_front();
          cmp_field("byte_valid", exp_w.byte_valid, out_data_o.byte_valid);
          cmp_field("reply_byte", exp_w.reply_byte, out_data_o.reply_byte);
          cmp_field("last", exp_w.last, out_data_o.last);
          cmp_field("lamp_level", exp_w.lamp_level, out_data_o.lamp_level);
          cmp_field("sleep_mode", exp_w.sleep_mode, out_data_o.sleep_mode);
          cmp_field("error_count", exp_w.error_count, out_data_o.error_count);
        end
      end
      // one long hold so the job queue fills and the input stalls
      if (!hold_done && accepted_cnt >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      stall_nx = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_nx = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall_nx = 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 16);
        stall_nx = 1'b1;
      end
      out_stall_i <= stall_nx;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("framed_command_receiver_tb failed");
    $finish;
  end

  initial begin
    int unsigned noise_cnt;
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  code;
    logic [7:0]  term;
    bit          drain_set;
    noise_cnt = 0;
    drain_set = 1'b0;

    // directed frames: every command, empty payloads, oversize, bad terminator
    push_frame(8'd1, fcr_pkg::CmdSetLevel, 8'hFF, fcr_pkg::EndByte, 1'b1, 8'h00);
    push_frame(8'd0, fcr_pkg::CmdReadAll, 8'h00, fcr_pkg::EndByte, 1'b1, 8'hFF);
    push_frame(8'd0, fcr_pkg::CmdSetSleep, 8'h00, fcr_pkg::EndByte, 1'b0, 8'h00);
    push_frame(8'd0, fcr_pkg::CmdReadLevel, 8'h00, fcr_pkg::EndByte, 1'b0, 8'h55);
    push_frame(8'd0, fcr_pkg::CmdReadPot, 8'h00, fcr_pkg::EndByte, 1'b0, 8'hFF);
    push_frame(fcr_pkg::MaxPayloadB, fcr_pkg::CmdReadLevel, 8'h00, fcr_pkg::EndByte,
               1'b0, 8'h00);
    push_frame(8'd0, 8'hFF, 8'h00, 8'h00, 1'b1, 8'hAA);

    while (rx_words_q.size() < FrameItems + noise_cnt) begin
      if (!drain_set && rx_words_q.size() > 250) begin
        want_drain = 1'b1;
        drain_set  = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        push_word(8'($urandom), 1'($urandom), 8'($urandom));
        noise_cnt++;
      end else if (pick == 1) begin
        // truncated frame, the next start byte lands inside it
        push_word(fcr_pkg::StartByte, 1'($urandom), 8'($urandom));
        push_word(8'($urandom_range(0, 3)), 1'($urandom), 8'($urandom));
      end else begin
        if (pick < 15)      len = 8'($urandom_range(0, 3));
        else if (pick < 18) len = 8'($urandom_range(4, fcr_pkg::MaxPayload - 1));
        else                len = 8'($urandom_range(fcr_pkg::MaxPayload, 255));
        code = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        term = ($urandom_range(0, 7) == 0) ? 8'($urandom) : fcr_pkg::EndByte;
        push_frame(len, code, 8'($urandom), term, 1'($urandom), 8'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_words_q.size() != 0 || in_valid_i || reply_words_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_cnt == 0 && reply_words_q.size() == 0) begin
      $display("framed_command_receiver_tb passed");
    end else begin
      $display("framed_command_receiver_tb failed");
    end
    $finish;
  end

endmodule
